/* hw/rtl/fse_pkg.sv */
// Package for the fraction sum evaluator.
// Holds character codes, status codes and the controller command/status types.
package fse_pkg;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam int unsigned RADIX     = 10;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// Datapath operations requested by the controller.
	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_CHAR    = 4'd1,  // digit accumulate or slash
		OP_F_START = 4'd2,  // latch term, check zero denominator
		OP_G1_INIT = 4'd3,  // gcd(n, d) setup
		OP_GCD     = 4'd4,  // start, bit step or swap of the gcd remainder
		OP_DIV_TERM= 4'd5,  // start a division by the gcd (n, d, q or mag)
		OP_DIV     = 4'd6,  // one quotient bit of the divider
		OP_G2_INIT = 4'd7,  // gcd(q, d) setup
		OP_MUL     = 4'd8,  // one product
		OP_ADD     = 4'd9,  // signed add of the products
		OP_G3_INIT = 4'd10, // gcd(mag, l) setup
		OP_COMMIT  = 4'd11, // write reduced sum
		OP_SET_SIGN= 4'd12, // clear term and take sign
		OP_CLEAR   = 4'd13  // end of line reset
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] sel;     // which division / product
		logic [7:0] chr;
	} fse_cmd_t;

	typedef struct packed {
		logic err;        // sticky error present
		logic gcd_done;   // gcd remainder operand is zero
		logic div_done;   // divider finished
		logic zero_mag;   // folded magnitude is zero
	} fse_stat_t;

endpackage

/* hw/rtl/fraction_sum_evaluator_unit.sv */
// A character that does not end a term passes through the start state and back to idle. A sign
// or end of line runs a fold through its three gcd loops, divisions, products and add; an
// error or a zero sum ends it sooner, and end of line adds an output state.
// Throughput: one character at a time; the next is taken once the unit is idle and the output is not stalled.
// Reset: arst_n clears the term, the running sum to 0/1 and the error status; the output register is not reset.
// Top level of the fraction sum evaluator. Depends on fse_pkg, fse_ctrl, fse_datapath.
module fraction_sum_evaluator_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_line,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] numerator,
	output logic [30:0] denominator,
	output logic        is_whole,
	output logic [1:0]  status
);

	fse_pkg::fse_cmd_t  cmd;
	fse_pkg::fse_stat_t stat;
	logic [31:0] r_num;
	logic [30:0] r_den;
	logic        r_whole, out_load;
	logic [1:0]  r_status;

	fse_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .char_code, .end_of_line,
		.stat, .cmd, .out_valid, .out_stall, .out_load
	);

	fse_datapath #(.VW(VALUE_WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .stat,
		.res_num(r_num), .res_den(r_den), .res_whole(r_whole), .res_status(r_status)
	);

	// Output register holds the result while downstream stalls.
	always_ff @(posedge clk) begin
		if (out_load) begin
			numerator <= r_num; denominator <= r_den;
			is_whole <= r_whole; status <= r_status;
		end
	end

endmodule

/* hw/rtl/fse_datapath.sv */
// Datapath of the fraction sum evaluator: term and sum registers, a shared
// bit-serial gcd/divider unit and a single multiplier. Depends on fse_pkg.
module fse_datapath #(
	parameter int VW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fse_pkg::fse_cmd_t  cmd,
	output fse_pkg::fse_stat_t stat,
	output logic [31:0]        res_num,
	output logic [30:0]        res_den,
	output logic               res_whole,
	output logic [1:0]         res_status
);

	localparam logic [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};
	localparam int CW = $clog2(VW + 1);

	logic [VW-1:0] tn_q, td_q, sn_q, sd_q;
	logic          tneg_q, inden_q, sneg_q;
	logic [1:0]    err_q;
	// Fold working registers.
	logic [VW-1:0] n_q, d_q, ga_q, gb_q, qa_q, da_q, l_q, a_q, b_q, mag_q;
	logic          rs_q;
	// Divider registers: dividend shifts out, quotient shifts in.
	logic [VW-1:0] dvd_q, dvs_q, rem_q, quo_q;
	logic [CW-1:0] cnt_q;

	// Digit accumulation with overflow check.
	logic [VW-1:0] acc_src, digit;
	logic [VW+3:0] acc_mul;
	logic [VW+4:0] acc_new;
	logic          acc_ovf;
	logic          is_digit;

	always_comb begin
		is_digit = (cmd.chr >= fse_pkg::CHAR_ZERO) && (cmd.chr <= fse_pkg::CHAR_NINE);
		acc_src  = inden_q ? td_q : tn_q;
		digit    = VW'(cmd.chr - fse_pkg::CHAR_ZERO);
		acc_mul  = (VW+4)'(acc_src) * (VW+4)'(fse_pkg::RADIX);
		acc_new  = (VW+5)'(acc_mul) + (VW+5)'(digit);
		acc_ovf  = acc_new > (VW+5)'(MAXV);
	end

	// Divider step: restoring, one quotient bit per cycle.
	logic [VW:0]   rem_sh;
	logic          rem_ge;
	always_comb begin
		rem_sh = {rem_q, dvd_q[VW-1]};
		rem_ge = rem_sh >= {1'b0, dvs_q};
	end

	// Shared multiplier, one product per command. The common denominator is
	// formed as q*(d/g), which equals (q/g)*d and leaves d free to be reduced.
	logic [VW-1:0]   m_a, m_b;
	logic [2*VW-1:0] m_p;
	always_comb begin
		unique case (cmd.sel)
			2'd0:    begin m_a = sd_q;  m_b = da_q; end
			2'd1:    begin m_a = sn_q;  m_b = da_q; end
			default: begin m_a = n_q;   m_b = qa_q; end
		endcase
		m_p = m_a * m_b;
	end

	// Signed combination of the two cross products.
	logic [VW:0] sum_ab;
	always_comb sum_ab = {1'b0, a_q} + {1'b0, b_q};

	always_comb begin
		stat.err      = err_q != fse_pkg::ST_OK;
		stat.gcd_done = gb_q == '0;
		stat.div_done = cnt_q == '0;
		stat.zero_mag = mag_q == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tn_q <= '0; td_q <= '0; tneg_q <= 1'b0; inden_q <= 1'b0;
			sn_q <= '0; sd_q <= VW'(1); sneg_q <= 1'b0; err_q <= fse_pkg::ST_OK;
			cnt_q <= '0;
		end else begin
			unique case (cmd.op)
				fse_pkg::OP_CHAR: begin
					if (is_digit) begin
						if (acc_ovf) begin
							if (err_q == fse_pkg::ST_OK) err_q <= fse_pkg::ST_OVERFLOW;
						end else if (inden_q) begin
							td_q <= VW'(acc_new);
						end else begin
							tn_q <= VW'(acc_new);
						end
					end else if (cmd.chr == fse_pkg::CHAR_SLASH) begin
						inden_q <= 1'b1;
					end
				end
				fse_pkg::OP_F_START: begin
					n_q <= tn_q;
					d_q <= inden_q ? td_q : VW'(1);
					if ((inden_q ? td_q : VW'(1)) == '0 && err_q == fse_pkg::ST_OK)
						err_q <= fse_pkg::ST_ZERO_DEN;
				end
				fse_pkg::OP_G1_INIT: begin
					ga_q <= n_q; gb_q <= d_q;
				end
				fse_pkg::OP_G2_INIT: begin
					ga_q <= sd_q; gb_q <= d_q;
				end
				fse_pkg::OP_G3_INIT: begin
					ga_q <= mag_q; gb_q <= l_q;
				end
				fse_pkg::OP_GCD: begin
					// Remainder by the divider unit; sel 3 starts, then step.
					if (cmd.sel == 2'd3) begin
						dvd_q <= ga_q; dvs_q <= gb_q; rem_q <= '0;
						cnt_q <= CW'(VW);
					end else if (cnt_q != '0) begin
						dvd_q <= dvd_q << 1;
						rem_q <= rem_ge ? VW'(rem_sh - {1'b0, dvs_q}) : VW'(rem_sh);
						cnt_q <= cnt_q - 1'b1;
					end else begin
						ga_q <= gb_q; gb_q <= rem_q;
					end
				end
				fse_pkg::OP_DIV_TERM: begin
					// sel picks dividend: 0 n, 1 d, 2 q(sd), 3 mag/l
					unique case (cmd.sel)
						2'd0:    dvd_q <= n_q;
						2'd1:    dvd_q <= d_q;
						2'd2:    dvd_q <= sd_q;
						default: dvd_q <= mag_q;
					endcase
					dvs_q <= ga_q; rem_q <= '0; quo_q <= '0;
					cnt_q <= CW'(VW);
				end
				fse_pkg::OP_DIV: begin
					if (cnt_q != '0) begin
						dvd_q <= dvd_q << 1;
						rem_q <= rem_ge ? VW'(rem_sh - {1'b0, dvs_q}) : VW'(rem_sh);
						quo_q <= {quo_q[VW-2:0], rem_ge};
						cnt_q <= cnt_q - 1'b1;
					end else begin
						unique case (cmd.sel)
							2'd0:    n_q   <= quo_q;
							2'd1:    begin d_q <= quo_q; da_q <= quo_q; end
							2'd2:    qa_q  <= quo_q;
							default: begin
								mag_q <= quo_q;
								dvd_q <= l_q; cnt_q <= CW'(VW);
								rem_q <= '0; quo_q <= '0;
							end
						endcase
					end
				end
				fse_pkg::OP_MUL: begin
					if (m_p > (2*VW)'(MAXV)) begin
						if (err_q == fse_pkg::ST_OK) err_q <= fse_pkg::ST_OVERFLOW;
					end else begin
						unique case (cmd.sel)
							2'd0:    l_q <= VW'(m_p);
							2'd1:    a_q <= VW'(m_p);
							default: b_q <= VW'(m_p);
						endcase
					end
					// da = d/g2 computed into da_q via divider; q stays sd.
				end
				fse_pkg::OP_ADD: begin
					if (sneg_q == tneg_q) begin
						if (sum_ab > {1'b0, MAXV}) begin
							if (err_q == fse_pkg::ST_OK) err_q <= fse_pkg::ST_OVERFLOW;
						end
						mag_q <= VW'(sum_ab);
						rs_q  <= sneg_q;
					end else if (a_q >= b_q) begin
						mag_q <= a_q - b_q; rs_q <= sneg_q;
					end else begin
						mag_q <= b_q - a_q; rs_q <= tneg_q;
					end
				end
				fse_pkg::OP_COMMIT: begin
					if (mag_q == '0) begin
						sn_q <= '0; sd_q <= VW'(1); sneg_q <= 1'b0;
					end else begin
						sn_q <= mag_q; sd_q <= quo_q; sneg_q <= rs_q;
					end
				end
				fse_pkg::OP_SET_SIGN: begin
					tn_q <= '0; td_q <= '0; inden_q <= 1'b0;
					tneg_q <= cmd.chr == fse_pkg::CHAR_MINUS;
				end
				fse_pkg::OP_CLEAR: begin
					tn_q <= '0; td_q <= '0; tneg_q <= 1'b0; inden_q <= 1'b0;
					sn_q <= '0; sd_q <= VW'(1); sneg_q <= 1'b0;
					err_q <= fse_pkg::ST_OK;
				end
				default: ;
			endcase
		end
	end

	// Result view of the current sum; sum magnitude kept unsigned with a sign.
	logic [VW-1:0] sn_signed;
	always_comb begin
		sn_signed  = sneg_q ? VW'(-sn_q) : sn_q;
		res_status = err_q;
		if (stat.err) begin
			res_num = '0; res_den = 31'd1; res_whole = 1'b0;
		end else begin
			res_num   = 32'(VW >= 32 ? sn_signed : {{(32 > VW ? 32 - VW : 1){sn_signed[VW-1]}},
				sn_signed});
			res_den   = 31'(sd_q);
			res_whole = sd_q == VW'(1);
		end
	end

endmodule

/* hw/rtl/fse_ctrl.sv */
// Controller of the fraction sum evaluator: sequences the datapath through
// a term fold (gcds, divisions, products). Depends on fse_pkg.
module fse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               end_of_line,
	input  fse_pkg::fse_stat_t stat,
	output fse_pkg::fse_cmd_t  cmd,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               out_load
);

	typedef enum logic [14:0] {
		S_IDLE   = 15'h0001,
		S_START  = 15'h0002,
		S_G1I    = 15'h0004,
		S_GCD    = 15'h0008,
		S_DIVI   = 15'h0010,
		S_DIV    = 15'h0020,
		S_G2I    = 15'h0040,
		S_MUL    = 15'h0080,
		S_ADD    = 15'h0100,
		S_G3I    = 15'h0200,
		S_COMMIT = 15'h0400,
		S_DONE   = 15'h0800,
		S_GSTEP  = 15'h1000,
		S_GSTART = 15'h2000,
		S_OUT    = 15'h4000
	} state_t;

	state_t     state_q;
	logic [7:0] chr_q;
	logic       eol_q;
	logic [1:0] phase_q;  // which gcd: 1 term, 2 denominators, 3 result
	logic [1:0] sel_q;
	logic       outv_q;

	logic accept;
	assign in_stall  = state_q != S_IDLE || (outv_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = outv_q;

	logic fold_char;
	always_comb fold_char = chr_q == fse_pkg::CHAR_PLUS || chr_q == fse_pkg::CHAR_MINUS;

	// The sign of the next term is taken only once the fold has used the old one.
	logic done_leave;
	always_comb done_leave = phase_q != 2'd0 || stat.err;

	always_comb begin
		cmd.op = fse_pkg::OP_NONE; cmd.sel = sel_q; cmd.chr = chr_q; out_load = 1'b0;
		unique case (state_q)
			S_IDLE:   begin cmd.chr = char_code; if (accept) cmd.op = fse_pkg::OP_CHAR; end
			S_START:  cmd.op = (fold_char || eol_q) ? fse_pkg::OP_F_START : fse_pkg::OP_NONE;
			S_G1I:    cmd.op = fse_pkg::OP_G1_INIT;
			S_G2I:    cmd.op = fse_pkg::OP_G2_INIT;
			S_G3I:    cmd.op = fse_pkg::OP_G3_INIT;
			S_GSTART: begin cmd.op = fse_pkg::OP_GCD; cmd.sel = 2'd3; end
			S_GSTEP:  cmd.op = fse_pkg::OP_NONE;
			S_GCD:    begin cmd.op = fse_pkg::OP_GCD; cmd.sel = 2'd0; end
			S_DIVI:   cmd.op = fse_pkg::OP_DIV_TERM;
			S_DIV:    cmd.op = fse_pkg::OP_DIV;
			S_MUL:    cmd.op = fse_pkg::OP_MUL;
			S_ADD:    cmd.op = fse_pkg::OP_ADD;
			S_COMMIT: cmd.op = fse_pkg::OP_COMMIT;
			S_DONE:   cmd.op = (done_leave && !eol_q && fold_char) ?
				fse_pkg::OP_SET_SIGN : fse_pkg::OP_NONE;
			S_OUT:    begin cmd.op = fse_pkg::OP_CLEAR; out_load = 1'b1; end
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; phase_q <= 2'd0; sel_q <= 2'd0; outv_q <= 1'b0;
			chr_q <= 8'd0; eol_q <= 1'b0;
		end else begin
			if (state_q == S_OUT) outv_q <= 1'b1;
			else if (outv_q && !out_stall) outv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					chr_q <= char_code; eol_q <= end_of_line; state_q <= S_START;
				end
				// Fold is entered on a sign or end of line; first it checks the term.
				S_START: state_q <= (fold_char || eol_q) ? S_DONE : S_IDLE;
				S_DONE: begin
					// Second visit after fold; first visit routes into the fold.
					if (!done_leave) begin
						phase_q <= 2'd1; state_q <= S_G1I;
					end else begin
						phase_q <= 2'd0; sel_q <= 2'd0;
						state_q <= eol_q ? S_OUT : S_IDLE;
					end
				end
				S_G1I: state_q <= S_GSTART;
				S_G2I: state_q <= S_GSTART;
				// The result gcd is skipped after an error or for a zero sum.
				S_G3I: begin
					sel_q <= 2'd3;
					if (stat.err) state_q <= S_DONE;
					else if (stat.zero_mag) state_q <= S_COMMIT;
					else state_q <= S_GSTART;
				end
				S_GSTART: state_q <= stat.gcd_done ? S_DIVI : S_GCD;
				S_GCD: if (stat.div_done) state_q <= S_GSTEP;
				S_GSTEP: state_q <= S_GSTART;
				S_DIVI: state_q <= S_DIV;
				S_DIV: if (stat.div_done) begin
					priority case (1'b1)
						phase_q == 2'd1 && sel_q == 2'd0: begin sel_q <= 2'd1; state_q <= S_DIVI; end
						phase_q == 2'd1: begin sel_q <= 2'd2; phase_q <= 2'd2; state_q <= S_G2I; end
						phase_q == 2'd2 && sel_q == 2'd2: begin sel_q <= 2'd1; state_q <= S_DIVI; end
						phase_q == 2'd2: begin sel_q <= 2'd0; state_q <= S_MUL; end
						default: begin
							// Result divide: mag first, then l (dvd reloaded).
							if (sel_q == 2'd3) begin sel_q <= 2'd2; state_q <= S_DIV; end
							else begin sel_q <= 2'd0; state_q <= S_COMMIT; end
						end
					endcase
				end
				S_MUL: begin
					if (stat.err) begin sel_q <= 2'd0; phase_q <= 2'd3; state_q <= S_DONE; end
					else if (sel_q == 2'd2) begin sel_q <= 2'd0; state_q <= S_ADD; end
					else sel_q <= sel_q + 2'd1;
				end
				// Phase 3 starts after the add; the gcd exit picks the result divide.
				S_ADD: begin
					phase_q <= 2'd3;
					state_q <= stat.err ? S_DONE : S_G3I;
				end
				S_COMMIT: begin phase_q <= 2'd3; state_q <= S_DONE; end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
